// ===== hdl/lbc_pkg.sv =====
`default_nettype none

package lbc_pkg;

  // Sequencer phase codes
  localparam logic [4:0] PH_OFF           = 5'd0;
  localparam logic [4:0] PH_INIT          = 5'd1;
  localparam logic [4:0] PH_INIT2         = 5'd2;
  localparam logic [4:0] PH_WRITE_DTR     = 5'd3;
  localparam logic [4:0] PH_REMOVE        = 5'd4;
  localparam logic [4:0] PH_REMOVE2       = 5'd5;
  localparam logic [4:0] PH_RANDOM        = 5'd6;
  localparam logic [4:0] PH_RANDOM2       = 5'd7;
  localparam logic [4:0] PH_RANDOM_WAIT   = 5'd8;
  localparam logic [4:0] PH_START_SEARCH  = 5'd9;
  localparam logic [4:0] PH_SEARCH_H      = 5'd10;
  localparam logic [4:0] PH_SEARCH_M      = 5'd11;
  localparam logic [4:0] PH_SEARCH_L      = 5'd12;
  localparam logic [4:0] PH_COMPARE       = 5'd13;
  localparam logic [4:0] PH_CHECK         = 5'd14;
  localparam logic [4:0] PH_PROGRAM       = 5'd15;
  localparam logic [4:0] PH_VERIFY        = 5'd16;
  localparam logic [4:0] PH_VERIFY_ANSWER = 5'd17;
  localparam logic [4:0] PH_WITHDRAW      = 5'd18;
  localparam logic [4:0] PH_TERMINATE     = 5'd19;

  // Bus command codes
  localparam logic [3:0] CMD_INITIALISE   = 4'd0;
  localparam logic [3:0] CMD_SET_DTR      = 4'd1;
  localparam logic [3:0] CMD_DTR_AS_SHORT = 4'd2;
  localparam logic [3:0] CMD_RANDOMISE    = 4'd3;
  localparam logic [3:0] CMD_SEARCH_H     = 4'd4;
  localparam logic [3:0] CMD_SEARCH_M     = 4'd5;
  localparam logic [3:0] CMD_SEARCH_L     = 4'd6;
  localparam logic [3:0] CMD_COMPARE      = 4'd7;
  localparam logic [3:0] CMD_PROGRAM      = 4'd8;
  localparam logic [3:0] CMD_VERIFY       = 4'd9;
  localparam logic [3:0] CMD_WITHDRAW     = 4'd10;
  localparam logic [3:0] CMD_TERMINATE    = 4'd11;

  // Item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic REG_FIRST_SHORT_ADDRESS = 1'b0;
  localparam logic REG_ONLY_UNADDRESSED    = 1'b1;

  localparam logic [23:0] ADDR_MASK     = 24'hFFFFFF;
  localparam logic [23:0] ADDR_TOP      = 24'h800000;
  localparam logic [4:0]  SEARCH_BITS   = 5'd24;
  localparam logic [7:0]  VALUE_ALL     = 8'hFF;
  localparam logic [7:0]  VALUE_BCAST   = 8'd63;
  localparam logic [7:0]  VERIFY_ACK    = 8'hFF;

  typedef struct packed {
    logic [4:0]  phase;
    logic [23:0] search_address;
    logic [4:0]  search_step;
    logic [7:0]  short_address;
  } lbc_state_t;

  typedef struct packed {
    logic       send_valid;
    logic [3:0] command_code;
    logic [7:0] command_value;
  } lbc_cmd_t;

  typedef struct packed {
    logic [7:0] first_short_address;
    logic       only_unaddressed;
  } lbc_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/lbc_step.sv =====
`default_nettype none

module lbc_step (
  input  var lbc_pkg::lbc_state_t st,
  input  var lbc_pkg::lbc_cfg_t   cfg,
  input  wire logic               kind,
  input  wire logic               bus_idle,
  input  wire logic               idle_long,
  input  wire logic               answer_present,
  input  wire logic [7:0]         answer_byte,
  output lbc_pkg::lbc_state_t     st_next,
  output lbc_pkg::lbc_cmd_t       cmd
);
  import lbc_pkg::*;

  logic [7:0]  init_value;
  logic [7:0]  prog_value;
  logic [23:0] step_delta;

  assign init_value = cfg.only_unaddressed ? VALUE_ALL : 8'd0;
  assign prog_value = {st.short_address[6:0], 1'b1};
  assign step_delta = ADDR_TOP >> st.search_step;

  // One sequencer step per item
  always_comb begin
    st_next = st;
    cmd     = '0;
    if (kind == KIND_START) begin
      st_next.short_address = cfg.first_short_address;
      st_next.phase         = PH_INIT;
    end else if (bus_idle) begin
      case (st.phase)
        PH_INIT: begin
          cmd           = '{1'b1, CMD_INITIALISE, init_value};
          st_next.phase = PH_INIT2;
        end
        PH_INIT2: begin
          cmd           = '{1'b1, CMD_INITIALISE, init_value};
          st_next.phase = cfg.only_unaddressed ? PH_RANDOM : PH_WRITE_DTR;
        end
        PH_WRITE_DTR: begin
          cmd           = '{1'b1, CMD_SET_DTR, VALUE_ALL};
          st_next.phase = PH_REMOVE;
        end
        PH_REMOVE: begin
          cmd           = '{1'b1, CMD_DTR_AS_SHORT, VALUE_BCAST};
          st_next.phase = PH_REMOVE2;
        end
        PH_REMOVE2: begin
          cmd           = '{1'b1, CMD_DTR_AS_SHORT, VALUE_BCAST};
          st_next.phase = PH_RANDOM;
        end
        PH_RANDOM: begin
          cmd           = '{1'b1, CMD_RANDOMISE, 8'd0};
          st_next.phase = PH_RANDOM2;
        end
        PH_RANDOM2: begin
          cmd           = '{1'b1, CMD_RANDOMISE, 8'd0};
          st_next.phase = PH_RANDOM_WAIT;
        end
        PH_RANDOM_WAIT: begin
          if (idle_long) begin
            st_next.phase = PH_START_SEARCH;
          end
        end
        PH_START_SEARCH: begin
          st_next.search_step    = 5'd0;
          st_next.search_address = ADDR_MASK;
          cmd                    = '{1'b1, CMD_SEARCH_H, ADDR_MASK[23:16]};
          st_next.phase          = PH_SEARCH_M;
        end
        PH_SEARCH_H: begin
          cmd           = '{1'b1, CMD_SEARCH_H, st.search_address[23:16]};
          st_next.phase = PH_SEARCH_M;
        end
        PH_SEARCH_M: begin
          cmd           = '{1'b1, CMD_SEARCH_M, st.search_address[15:8]};
          st_next.phase = PH_SEARCH_L;
        end
        PH_SEARCH_L: begin
          cmd           = '{1'b1, CMD_SEARCH_L, st.search_address[7:0]};
          st_next.phase = PH_COMPARE;
        end
        PH_COMPARE: begin
          cmd           = '{1'b1, CMD_COMPARE, 8'd0};
          st_next.phase = PH_CHECK;
        end
        PH_CHECK: begin
          // Binary search: answer means some device is at or below the address
          if (answer_present) begin
            if (st.search_step >= SEARCH_BITS) begin
              st_next.phase = PH_PROGRAM;
            end else begin
              st_next.search_address = st.search_address - step_delta;
              st_next.phase          = PH_SEARCH_H;
            end
          end else if (st.search_step == 5'd0 || st.search_step > SEARCH_BITS) begin
            st_next.phase = PH_TERMINATE;
          end else if (st.search_step == SEARCH_BITS) begin
            st_next.search_address = st.search_address + 24'd1;
            st_next.phase          = PH_SEARCH_H;
          end else begin
            st_next.search_address = st.search_address + step_delta;
            st_next.phase          = PH_SEARCH_H;
          end
          st_next.search_step = st.search_step + 5'd1;
        end
        PH_PROGRAM: begin
          cmd           = '{1'b1, CMD_PROGRAM, prog_value};
          st_next.phase = PH_VERIFY;
        end
        PH_VERIFY: begin
          cmd           = '{1'b1, CMD_VERIFY, prog_value};
          st_next.phase = PH_VERIFY_ANSWER;
        end
        PH_VERIFY_ANSWER: begin
          if (answer_present && answer_byte == VERIFY_ACK) begin
            st_next.short_address = st.short_address + 8'd1;
            st_next.phase         = PH_WITHDRAW;
          end else begin
            st_next.phase = PH_TERMINATE;
          end
        end
        PH_WITHDRAW: begin
          cmd           = '{1'b1, CMD_WITHDRAW, 8'd0};
          st_next.phase = PH_START_SEARCH;
        end
        PH_TERMINATE: begin
          cmd           = '{1'b1, CMD_TERMINATE, 8'd0};
          st_next.phase = PH_OFF;
        end
        default: begin
          st_next = st;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lighting_bus_commissioning_fsm.sv =====
// Commissioning sequencer for a lighting control bus, master side.
// Input channel (in_valid/in_ready): a start item (kind 0) restarts the
// sequence; a tick item (kind 1) reports one bus observation and, when the
// bus is idle, may issue one command (code and value byte).
// Output channel (out_valid/out_ready): exactly one result item per input
// item, in order: send_valid, command_code, command_value, active and
// next_address as they stand after that item. The result is registered and
// presented in the cycle after its item is accepted. One item per cycle
// unless the receiver stalls, set by the single registered state update
// (phase, search address, step, short address). While the receiver stalls
// the result register holds its item and in_ready drops; it rises again
// in the same cycle the result is taken. The user must write configuration
// (cfg_write/cfg_index/cfg_data) only while idle; the block does not
// enforce it. Reset: off phase, search address all ones, step and short
// address zero, both configuration registers zero, output register empty.
`default_nettype none

module lighting_bus_commissioning_fsm (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       kind,
  input  wire logic       bus_idle,
  input  wire logic       idle_long,
  input  wire logic       answer_present,
  input  wire logic [7:0] answer_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            send_valid,
  output logic [3:0]      command_code,
  output logic [7:0]      command_value,
  output logic            active,
  output logic [7:0]      next_address
);
  import lbc_pkg::*;

  lbc_cfg_t   cfg;
  lbc_state_t st;
  lbc_state_t st_next;
  lbc_cmd_t   cmd;
  logic       accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  lbc_step u_step (
    .st             (st),
    .cfg            (cfg),
    .kind           (kind),
    .bus_idle       (bus_idle),
    .idle_long      (idle_long),
    .answer_present (answer_present),
    .answer_byte    (answer_byte),
    .st_next        (st_next),
    .cmd            (cmd)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_SHORT_ADDRESS: cfg.first_short_address <= cfg_data;
        REG_ONLY_UNADDRESSED:    cfg.only_unaddressed    <= cfg_data[0];
        default:                 cfg <= cfg;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_OFF;
      st.search_address <= ADDR_MASK;
      st.search_step    <= 5'd0;
      st.short_address  <= 8'd0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      send_valid    <= cmd.send_valid;
      command_code  <= cmd.command_code;
      command_value <= cmd.command_value;
      active        <= (st_next.phase != PH_OFF);
      next_address  <= st_next.short_address;
    end
  end

endmodule

`default_nettype wire

// ===== tb/lighting_bus_commissioning_fsm_tb.sv =====
`timescale 1ns / 100ps

module lighting_bus_commissioning_fsm_tb;
  import lbc_pkg::*;

  typedef struct packed {
    logic       kind;
    logic       bus_idle;
    logic       idle_long;
    logic       answer_present;
    logic [7:0] answer_byte;
  } bus_item_t;

  typedef struct packed {
    lbc_cmd_t   cmd;
    logic       active;
    logic [7:0] next_address;
  } bus_result_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       kind;
  logic       bus_idle;
  logic       idle_long;
  logic       answer_present;
  logic [7:0] answer_byte;
  logic       out_valid;
  logic       out_ready;
  logic       send_valid;
  logic [3:0] command_code;
  logic [7:0] command_value;
  logic       active;
  logic [7:0] next_address;

  lighting_bus_commissioning_fsm dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .bus_idle       (bus_idle),
    .idle_long      (idle_long),
    .answer_present (answer_present),
    .answer_byte    (answer_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .send_valid     (send_valid),
    .command_code   (command_code),
    .command_value  (command_value),
    .active         (active),
    .next_address   (next_address)
  );

  // Items waiting to be offered, and commands predicted but not yet seen
  bus_item_t   bus_items[$];
  bus_result_t predicted_cmds[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int mismatch_count;
  int result_count;
  int counted_items;
  bit in_taken;

  // Shadow copy of the sequencer state and its registers
  logic [4:0]  seq_phase;
  logic [23:0] seq_addr;
  logic [4:0]  seq_step;
  logic [7:0]  seq_short;
  logic [7:0]  cfg_first;
  logic        cfg_only;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic lbc_cmd_t issue_cmd(logic [3:0] code, logic [7:0] value);
    lbc_cmd_t c;
    c.send_valid    = 1'b1;
    c.command_code  = code;
    c.command_value = value;
    return c;
  endfunction

  // One item through the sequencer: updates the shadow state, returns the command
  function automatic bus_result_t sequencer_step(bus_item_t it);
    bus_result_t r;
    logic [7:0]  init_value;
    logic [7:0]  prog_value;
    r = '0;
    init_value = cfg_only ? VALUE_ALL : 8'd0;
    prog_value = {seq_short[6:0], 1'b1};
    if (it.kind == KIND_START) begin
      seq_short = cfg_first;
      seq_phase = PH_INIT;
    end else if (it.bus_idle) begin
      case (seq_phase)
        PH_INIT: begin
          r.cmd = issue_cmd(CMD_INITIALISE, init_value);
          seq_phase = PH_INIT2;
        end
        PH_INIT2: begin
          r.cmd = issue_cmd(CMD_INITIALISE, init_value);
          seq_phase = cfg_only ? PH_RANDOM : PH_WRITE_DTR;
        end
        PH_WRITE_DTR: begin
          r.cmd = issue_cmd(CMD_SET_DTR, VALUE_ALL);
          seq_phase = PH_REMOVE;
        end
        PH_REMOVE: begin
          r.cmd = issue_cmd(CMD_DTR_AS_SHORT, VALUE_BCAST);
          seq_phase = PH_REMOVE2;
        end
        PH_REMOVE2: begin
          r.cmd = issue_cmd(CMD_DTR_AS_SHORT, VALUE_BCAST);
          seq_phase = PH_RANDOM;
        end
        PH_RANDOM: begin
          r.cmd = issue_cmd(CMD_RANDOMISE, 8'd0);
          seq_phase = PH_RANDOM2;
        end
        PH_RANDOM2: begin
          r.cmd = issue_cmd(CMD_RANDOMISE, 8'd0);
          seq_phase = PH_RANDOM_WAIT;
        end
        PH_RANDOM_WAIT: begin
          if (it.idle_long) seq_phase = PH_START_SEARCH;
        end
        PH_START_SEARCH: begin
          seq_step = 5'd0;
          seq_addr = ADDR_MASK;
          r.cmd = issue_cmd(CMD_SEARCH_H, seq_addr[23:16]);
          seq_phase = PH_SEARCH_M;
        end
        PH_SEARCH_H: begin
          r.cmd = issue_cmd(CMD_SEARCH_H, seq_addr[23:16]);
          seq_phase = PH_SEARCH_M;
        end
        PH_SEARCH_M: begin
          r.cmd = issue_cmd(CMD_SEARCH_M, seq_addr[15:8]);
          seq_phase = PH_SEARCH_L;
        end
        PH_SEARCH_L: begin
          r.cmd = issue_cmd(CMD_SEARCH_L, seq_addr[7:0]);
          seq_phase = PH_COMPARE;
        end
        PH_COMPARE: begin
          r.cmd = issue_cmd(CMD_COMPARE, 8'd0);
          seq_phase = PH_CHECK;
        end
        PH_CHECK: begin
          // answer narrows the search downward; silence moves it up or ends it
          if (it.answer_present) begin
            if (seq_step >= SEARCH_BITS) begin
              seq_phase = PH_PROGRAM;
            end else begin
              seq_addr = seq_addr - (ADDR_TOP >> seq_step);
              seq_phase = PH_SEARCH_H;
            end
          end else if (seq_step == 5'd0 || seq_step > SEARCH_BITS) begin
            seq_phase = PH_TERMINATE;
          end else if (seq_step == SEARCH_BITS) begin
            seq_addr = seq_addr + 24'd1;
            seq_phase = PH_SEARCH_H;
          end else begin
            seq_addr = seq_addr + (ADDR_TOP >> seq_step);
            seq_phase = PH_SEARCH_H;
          end
          seq_step = seq_step + 5'd1;
        end
        PH_PROGRAM: begin
          r.cmd = issue_cmd(CMD_PROGRAM, prog_value);
          seq_phase = PH_VERIFY;
        end
        PH_VERIFY: begin
          r.cmd = issue_cmd(CMD_VERIFY, prog_value);
          seq_phase = PH_VERIFY_ANSWER;
        end
        PH_VERIFY_ANSWER: begin
          if (it.answer_present && it.answer_byte == VERIFY_ACK) begin
            seq_short = seq_short + 8'd1;
            seq_phase = PH_WITHDRAW;
          end else begin
            seq_phase = PH_TERMINATE;
          end
        end
        PH_WITHDRAW: begin
          r.cmd = issue_cmd(CMD_WITHDRAW, 8'd0);
          seq_phase = PH_START_SEARCH;
        end
        PH_TERMINATE: begin
          r.cmd = issue_cmd(CMD_TERMINATE, 8'd0);
          seq_phase = PH_OFF;
        end
        default: begin
        end
      endcase
    end
    r.active = (seq_phase != PH_OFF);
    r.next_address = seq_short;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $realtime, result_count, msg);
    mismatch_count++;
  endtask

  // Driver: offers the next item at the falling edge
  always @(negedge clk) begin
    bus_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (bus_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = bus_items.pop_front();
        in_valid       <= 1'b1;
        kind           <= it.kind;
        bus_idle       <= it.bus_idle;
        idle_long      <= it.idle_long;
        answer_present <= it.answer_present;
        answer_byte    <= it.answer_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results first, then predict for the item taken this edge
  always @(posedge clk) begin
    bus_item_t   it;
    bus_result_t want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_cmds.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = predicted_cmds.pop_front();
          if (send_valid !== want.cmd.send_valid)
            report_mismatch($sformatf("send_valid %h, want %h",
                                      send_valid, want.cmd.send_valid));
          if (command_code !== want.cmd.command_code)
            report_mismatch($sformatf("command_code %h, want %h",
                                      command_code, want.cmd.command_code));
          if (command_value !== want.cmd.command_value)
            report_mismatch($sformatf("command_value %h, want %h",
                                      command_value, want.cmd.command_value));
          if (active !== want.active)
            report_mismatch($sformatf("active %h, want %h", active, want.active));
          if (next_address !== want.next_address)
            report_mismatch($sformatf("next_address %h, want %h",
                                      next_address, want.next_address));
        end
        result_count++;
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        it = '{kind, bus_idle, idle_long, answer_present, answer_byte};
        predicted_cmds.push_back(sequencer_step(it));
      end
    end
  end

  task automatic queue_item(logic k, logic idle, logic lng, logic ans, logic [7:0] b);
    bus_items.push_back('{k, idle, lng, ans, b});
    counted_items++;
  endtask

  // A commissioning run with random bus observations; answers lean toward
  // present and toward the verify acknowledge so the search reaches programming
  task automatic queue_session(int room);
    int n;
    int stray;
    n = $urandom_range(99) < 25 ? $urandom_range(40, 1) : $urandom_range(400, 120);
    if (n > room) n = room;
    // noise ahead of the start: ticks that may land while off
    stray = $urandom_range(3);
    repeat (stray)
      queue_item(KIND_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 8'($urandom_range(255)));
    queue_item(KIND_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
               1'($urandom_range(1)), 8'($urandom_range(255)));
    repeat (n) begin
      if ($urandom_range(199) == 0)
        queue_item(KIND_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 8'($urandom_range(255)));
      else
        queue_item(KIND_TICK, $urandom_range(99) < 80, $urandom_range(99) < 35,
                   $urandom_range(99) < 65,
                   $urandom_range(99) < 65 ? VERIFY_ACK : 8'($urandom_range(255)));
    end
  endtask

  task automatic queue_random(int target);
    counted_items = 0;
    while (counted_items < target) queue_session(target - counted_items);
  endtask

  task automatic write_register(logic idx, logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_FIRST_SHORT_ADDRESS) cfg_first = value;
    else cfg_only = value[0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (!(bus_items.size() == 0 && (!in_valid || in_taken) && predicted_cmds.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FIRST_SHORT_ADDRESS;
    cfg_data = 8'd0;
    in_valid = 1'b0;
    kind = KIND_START;
    bus_idle = 1'b0;
    idle_long = 1'b0;
    answer_present = 1'b0;
    answer_byte = 8'd0;
    out_ready = 1'b0;
    in_taken = 1'b0;
    hold_left = 0;
    mismatch_count = 0;
    result_count = 0;
    counted_items = 0;
    send_idle_pct = 32;
    recv_stall_pct = 85;
    seq_phase = PH_OFF;
    seq_addr = ADDR_MASK;
    seq_step = 5'd0;
    seq_short = 8'd0;
    cfg_first = 8'd0;
    cfg_only = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short address at the top so the first increment wraps
    write_register(REG_FIRST_SHORT_ADDRESS, 8'hFF);
    write_register(REG_ONLY_UNADDRESSED, 8'h00);

    // Directed: ticks while off, restart while running, the full preamble,
    // silence at the first compare ending the run, then a tick once off again
    queue_item(KIND_TICK, 1'b1, 1'b1, 1'b1, 8'hFF);
    queue_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
    queue_item(KIND_START, 1'b1, 1'b1, 1'b1, 8'hFF);
    queue_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 8'h00);
    queue_item(KIND_TICK, 1'b0, 1'b1, 1'b1, 8'hFF);
    queue_item(KIND_START, 1'b0, 1'b0, 1'b0, 8'h00);
    repeat (7) queue_item(KIND_TICK, 1'b1, 1'b0, 1'b1, 8'hA5);
    queue_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 8'h00);
    queue_item(KIND_TICK, 1'b1, 1'b1, 1'b0, 8'h5A);
    repeat (4) queue_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 8'h00);
    queue_item(KIND_TICK, 1'b1, 1'b1, 1'b0, 8'hFF);
    queue_item(KIND_TICK, 1'b1, 1'b1, 1'b1, 8'hFF);
    queue_item(KIND_TICK, 1'b1, 1'b1, 1'b1, 8'hFF);

    queue_random(400);
    wait_drained();

    // Only unaddressed devices, sender now the slow side
    write_register(REG_FIRST_SHORT_ADDRESS, 8'h00);
    write_register(REG_ONLY_UNADDRESSED, 8'h01);
    send_idle_pct = 85;
    recv_stall_pct = 32;
    queue_random(400);
    wait_drained();

    // No idling; the receiver holds off long enough to back up the input
    write_register(REG_FIRST_SHORT_ADDRESS, 8'($urandom_range(255)));
    write_register(REG_ONLY_UNADDRESSED, 8'($urandom_range(1)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    queue_random(250);
    wait_drained();

    write_register(REG_FIRST_SHORT_ADDRESS, 8'd127);
    write_register(REG_ONLY_UNADDRESSED, 8'h00);
    queue_random(200);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lighting_bus_commissioning_fsm: match");
    end else begin
      $display("lighting_bus_commissioning_fsm: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("lighting_bus_commissioning_fsm: mismatch");
    $finish;
  end

endmodule
